// ----- src/tslg_pkg.sv -----
`timescale 1ns / 1ps

package tslg_pkg;

  // strip geometry and field widths
  localparam int STRIP_LENGTH = 256;
  localparam int POS_W        = 8;
  localparam int COLOR_W      = 8;
  localparam int BOUND_W      = 9;
  localparam int NUM_CH       = 3;

  // ramp divider: numerator k*d + (n-1) fits in BOUND_W + COLOR_W bits,
  // quotient never exceeds the colour span
  localparam int NUM_W          = BOUND_W + COLOR_W;
  localparam int Q_W            = COLOR_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;

  // configuration port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUND_ONE   = 3'd0,
    CFG_BOUND_TWO   = 3'd1,
    CFG_BOUND_THREE = 3'd2,
    CFG_BOUND_FOUR  = 3'd3,
    CFG_BOUND_FIVE  = 3'd4,
    CFG_BOUND_SIX   = 3'd5
  } cfg_reg_t;

  typedef logic [COLOR_W-1:0] color_t;
  typedef color_t [NUM_CH-1:0] rgb_t;
  typedef logic [BOUND_W-1:0] bound_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [Q_W-1:0]     quot_t;

  // control that travels with each beat
  typedef struct packed {
    logic valid;
    logic written;
  } beat_ctl_t;

endpackage

// ----- src/tslg_ramp.sv -----
`timescale 1ns / 1ps

module tslg_ramp import tslg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  beat_ctl_t            ctl_i,
  input  bound_t               k_i,
  input  bound_t               n_i,
  input  rgb_t                 s_i,
  input  rgb_t                 d_i,
  input  logic [NUM_CH-1:0]    neg_i,
  output beat_ctl_t            ctl_o,
  output rgb_t                 rgb_o
);

  // multiply stage
  beat_ctl_t          m_ctl_r, m_ctl_nxt;
  num_t [NUM_CH-1:0]  m_num_r, m_num_nxt;
  bound_t             m_n_r;
  rgb_t               m_s_r;
  logic [NUM_CH-1:0]  m_neg_r;

  // divider stages
  beat_ctl_t                          dv_ctl_r   [DIV_STAGES];
  beat_ctl_t                          dv_ctl_nxt [DIV_STAGES];
  num_t [NUM_CH-1:0]                  dv_rem_r   [DIV_STAGES];
  num_t [NUM_CH-1:0]                  dv_rem_nxt [DIV_STAGES];
  logic [NUM_CH-1:0][Q_W-1:0]         dv_q_r     [DIV_STAGES];
  logic [NUM_CH-1:0][Q_W-1:0]         dv_q_nxt   [DIV_STAGES];
  bound_t                             dv_n_r     [DIV_STAGES];
  bound_t                             dv_n_nxt   [DIV_STAGES];
  rgb_t                               dv_s_r     [DIV_STAGES];
  rgb_t                               dv_s_nxt   [DIV_STAGES];
  logic [NUM_CH-1:0]                  dv_neg_r   [DIV_STAGES];
  logic [NUM_CH-1:0]                  dv_neg_nxt [DIV_STAGES];

  // output stage
  beat_ctl_t out_ctl_r;
  rgb_t      out_rgb_r, out_rgb_nxt;

  // form k*d, plus n-1 where the ramp falls so the quotient rounds up and the colour rounds down
  always_comb begin
    m_ctl_nxt = ctl_i;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      m_num_nxt[ch] = NUM_W'(k_i) * NUM_W'(d_i[ch]);
      if (neg_i[ch]) begin
        m_num_nxt[ch] = m_num_nxt[ch] + NUM_W'(n_i) - NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_ctl_r <= '0;
    end else begin
      m_ctl_r <= m_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_num_r <= m_num_nxt;
    m_n_r   <= n_i;
    m_s_r   <= s_i;
    m_neg_r <= neg_i;
  end

  // restoring division, BITS_PER_STAGE quotient bits per stage
  always_comb begin
    int   bit_idx;
    num_t shifted;
    for (int st = 0; st < DIV_STAGES; st++) begin
      if (st == 0) begin
        dv_ctl_nxt[st] = m_ctl_r;
        dv_rem_nxt[st] = m_num_r;
        dv_q_nxt[st]   = '0;
        dv_n_nxt[st]   = m_n_r;
        dv_s_nxt[st]   = m_s_r;
        dv_neg_nxt[st] = m_neg_r;
      end else begin
        dv_ctl_nxt[st] = dv_ctl_r[st-1];
        dv_rem_nxt[st] = dv_rem_r[st-1];
        dv_q_nxt[st]   = dv_q_r[st-1];
        dv_n_nxt[st]   = dv_n_r[st-1];
        dv_s_nxt[st]   = dv_s_r[st-1];
        dv_neg_nxt[st] = dv_neg_r[st-1];
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
          bit_idx = Q_W - 1 - st * BITS_PER_STAGE - j;
          shifted = NUM_W'(dv_n_nxt[st]) << bit_idx;
          if (dv_rem_nxt[st][ch] >= shifted) begin
            dv_rem_nxt[st][ch]        = dv_rem_nxt[st][ch] - shifted;
            dv_q_nxt[st][ch][bit_idx] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int st = 0; st < DIV_STAGES; st++) begin
        dv_ctl_r[st] <= '0;
      end
    end else begin
      for (int st = 0; st < DIV_STAGES; st++) begin
        dv_ctl_r[st] <= dv_ctl_nxt[st];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int st = 0; st < DIV_STAGES; st++) begin
      dv_rem_r[st] <= dv_rem_nxt[st];
      dv_q_r[st]   <= dv_q_nxt[st];
      dv_n_r[st]   <= dv_n_nxt[st];
      dv_s_r[st]   <= dv_s_nxt[st];
      dv_neg_r[st] <= dv_neg_nxt[st];
    end
  end

  // step from the start colour by the quotient
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (dv_neg_r[DIV_STAGES-1][ch]) begin
        out_rgb_nxt[ch] = dv_s_r[DIV_STAGES-1][ch] - dv_q_r[DIV_STAGES-1][ch];
      end else begin
        out_rgb_nxt[ch] = dv_s_r[DIV_STAGES-1][ch] + dv_q_r[DIV_STAGES-1][ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else begin
      out_ctl_r <= dv_ctl_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_rgb_r <= out_rgb_nxt;
  end

  assign ctl_o = out_ctl_r;
  assign rgb_o = out_rgb_r;

endmodule

// ----- src/three_stop_led_gradient_core.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// --------  -------------------------  ---------------------------------------
// input     start & !busy              in_led_position, in_{first,second,
//                                      third}_{red,green,blue}
// result    out_strobe (one cycle)     out_red, out_green, out_blue,
//                                      out_pixel_written
// config    cfg_we                     cfg_index, cfg_data
//
// busy is never raised: one beat may be taken every clock.
// A result passes through segment select, multiply, four divider stages of
// two quotient bits each, then the output register.
// Synchronous active-low reset clears the boundaries and all valid bits.
// The receiver cannot stall, so the pipeline always advances.

module three_stop_led_gradient_core import tslg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [POS_W-1:0]     in_led_position,
  input  logic [COLOR_W-1:0]   in_first_red,
  input  logic [COLOR_W-1:0]   in_first_green,
  input  logic [COLOR_W-1:0]   in_first_blue,
  input  logic [COLOR_W-1:0]   in_second_red,
  input  logic [COLOR_W-1:0]   in_second_green,
  input  logic [COLOR_W-1:0]   in_second_blue,
  input  logic [COLOR_W-1:0]   in_third_red,
  input  logic [COLOR_W-1:0]   in_third_green,
  input  logic [COLOR_W-1:0]   in_third_blue,
  output logic                 out_strobe,
  output logic [COLOR_W-1:0]   out_red,
  output logic [COLOR_W-1:0]   out_green,
  output logic [COLOR_W-1:0]   out_blue,
  output logic                 out_pixel_written,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOUND_W-1:0]   cfg_data
);

  // boundary registers
  bound_t bound_one_r, bound_two_r, bound_three_r;
  bound_t bound_four_r, bound_five_r, bound_six_r;

  // select stage
  beat_ctl_t         s1_ctl_r, s1_ctl_nxt;
  bound_t            s1_k_r, s1_k_nxt;
  bound_t            s1_n_r, s1_n_nxt;
  rgb_t              s1_s_r;
  rgb_t              s1_d_r, s1_d_nxt;
  logic [NUM_CH-1:0] s1_neg_r, s1_neg_nxt;

  rgb_t   col_a, col_b, col_c;
  rgb_t   from_rgb, to_rgb;
  bound_t pos9;
  logic   accept;

  beat_ctl_t ramp_ctl;
  rgb_t      ramp_rgb;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign col_a = {in_first_blue, in_first_green, in_first_red};
  assign col_b = {in_second_blue, in_second_green, in_second_red};
  assign col_c = {in_third_blue, in_third_green, in_third_red};
  assign pos9  = BOUND_W'(in_led_position);

  // hold the boundaries; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_one_r   <= '0;
      bound_two_r   <= '0;
      bound_three_r <= '0;
      bound_four_r  <= '0;
      bound_five_r  <= '0;
      bound_six_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BOUND_ONE:   bound_one_r   <= cfg_data;
        CFG_BOUND_TWO:   bound_two_r   <= cfg_data;
        CFG_BOUND_THREE: bound_three_r <= cfg_data;
        CFG_BOUND_FOUR:  bound_four_r  <= cfg_data;
        CFG_BOUND_FIVE:  bound_five_r  <= cfg_data;
        CFG_BOUND_SIX:   bound_six_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pick the segment; solid and unwritten beats become a ramp with k = 0
  always_comb begin
    from_rgb           = '0;
    to_rgb             = '0;
    s1_k_nxt           = '0;
    s1_n_nxt           = BOUND_W'(1);
    s1_ctl_nxt.valid   = accept;
    s1_ctl_nxt.written = 1'b1;
    priority if (int'(in_led_position) >= STRIP_LENGTH) begin
      s1_ctl_nxt.written = 1'b0;
    end else if (pos9 < bound_one_r) begin
      from_rgb = col_a;
      to_rgb   = col_a;
    end else if (pos9 < bound_two_r) begin
      from_rgb = col_a;
      to_rgb   = col_b;
      s1_k_nxt = pos9 - bound_one_r;
      s1_n_nxt = bound_two_r - bound_one_r;
    end else if (pos9 < bound_three_r) begin
      from_rgb = col_b;
      to_rgb   = col_b;
    end else if (pos9 < bound_four_r) begin
      from_rgb = col_b;
      to_rgb   = col_c;
      s1_k_nxt = pos9 - bound_three_r;
      s1_n_nxt = bound_four_r - bound_three_r;
    end else if (pos9 < bound_five_r) begin
      from_rgb = col_c;
      to_rgb   = col_c;
    end else if (pos9 < bound_six_r) begin
      from_rgb = col_c;
      to_rgb   = col_a;
      s1_k_nxt = pos9 - bound_five_r;
      s1_n_nxt = bound_six_r - bound_five_r;
    end else begin
      s1_ctl_nxt.written = 1'b0;
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s1_neg_nxt[ch] = to_rgb[ch] < from_rgb[ch];
      s1_d_nxt[ch]   = s1_neg_nxt[ch] ? from_rgb[ch] - to_rgb[ch]
                                      : to_rgb[ch] - from_rgb[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_k_r   <= s1_k_nxt;
    s1_n_r   <= s1_n_nxt;
    s1_s_r   <= from_rgb;
    s1_d_r   <= s1_d_nxt;
    s1_neg_r <= s1_neg_nxt;
  end

  // interpolate: multiply, divide, step
  tslg_ramp u_ramp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (s1_ctl_r),
    .k_i   (s1_k_r),
    .n_i   (s1_n_r),
    .s_i   (s1_s_r),
    .d_i   (s1_d_r),
    .neg_i (s1_neg_r),
    .ctl_o (ramp_ctl),
    .rgb_o (ramp_rgb)
  );

  assign out_strobe        = ramp_ctl.valid;
  assign out_pixel_written = ramp_ctl.written;
  assign out_red           = ramp_rgb[0];
  assign out_green         = ramp_rgb[1];
  assign out_blue          = ramp_rgb[2];

endmodule
